>>> rtl/c6502s_pkg.sv
package c6502s_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BRK     = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_OP,
    S_B1,
    S_B2,
    S_MEM_REQ,
    S_MEM_WAIT,
    S_EXEC,
    S_PUSH_LO,
    S_DONE
  } state_e;

  localparam logic [7:0] OP_BRK   = 8'h00;
  localparam logic [7:0] OP_ASL   = 8'h0a;
  localparam logic [7:0] OP_JSR   = 8'h20;
  localparam logic [7:0] OP_BMI   = 8'h30;
  localparam logic [7:0] OP_ROLZX = 8'h36;
  localparam logic [7:0] OP_ADCZ  = 8'h65;
  localparam logic [7:0] OP_ADCI  = 8'h69;
  localparam logic [7:0] OP_STAZ  = 8'h85;
  localparam logic [7:0] OP_TXA   = 8'h8a;
  localparam logic [7:0] OP_LDY   = 8'ha0;
  localparam logic [7:0] OP_LDX   = 8'ha2;
  localparam logic [7:0] OP_LDA   = 8'ha9;
  localparam logic [7:0] OP_DEX   = 8'hca;
  localparam logic [7:0] OP_CMP   = 8'hcd;
  localparam logic [7:0] OP_SBC   = 8'he9;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [15:0] pc_out;
    logic [7:0]  flags_out;
  } rsp_t;

endpackage

>>> rtl/c6502s_ram.sv
module c6502s_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/cpu6502_subset_step_top.sv
// Commands are taken one at a time; busy stays high until the cycle of the result strobe.
// The single-port memory sets the rate: opcode, operands, data and stack go through one port.
// Reset clears A, X, Y and PC, sets SP to 0xff and flags to 0x20; memory is not cleared.
// The result is shown for one cycle on result_valid_o; the receiver cannot stall.
module cpu6502_subset_step_top import c6502s_pkg::*; #(
  parameter int MEM_DEPTH = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t result_o
);

  localparam int AW = $clog2(MEM_DEPTH);

  state_e state_q, state_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  op_q, op_d, b1_q, b1_d, b2_q, b2_d;
  logic [1:0]  status_d;
  logic [7:0]  rbyte_d;
  rsp_t        res_q, res_d;
  logic        rv_q, rv_d;

  logic          we;
  logic [15:0]   addr;
  logic [7:0]    wdata, rdata;

  c6502s_ram #(.Width(8), .Depth(MEM_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr[AW-1:0]),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  logic        need_b1, need_b2, need_mem;
  logic [7:0]  zpx;
  logic [15:0] mem_addr;
  always_comb begin
    zpx = b1_q + x_q;
    mem_addr = (op_q == OP_CMP) ? {b2_q, b1_q} :
               (op_q == OP_ROLZX) ? {8'd0, zpx} : {8'd0, b1_q};
    need_b1  = 1'b1;
    need_b2  = 1'b0;
    need_mem = 1'b0;
    case (op_q)
      OP_BRK, OP_ASL, OP_TXA, OP_DEX: need_b1 = 1'b0;
      OP_JSR: need_b2 = 1'b1;
      OP_CMP: begin need_b2 = 1'b1; need_mem = 1'b1; end
      OP_ROLZX, OP_ADCZ: need_mem = 1'b1;
      OP_BMI, OP_ADCI, OP_STAZ, OP_LDY, OP_LDX, OP_LDA, OP_SBC: ;
      default: need_b1 = 1'b0;
    endcase
  end

  // adder shared by ADC and SBC
  logic [7:0] add_m, add_r, cmp_diff;
  logic [8:0] add_sum;
  logic       add_v;
  always_comb begin
    add_m    = (op_q == OP_SBC) ? ~b1_q : ((op_q == OP_ADCZ) ? rdata : b1_q);
    add_sum  = {1'b0, a_q} + {1'b0, add_m} + {8'd0, p_q[0]};
    add_r    = add_sum[7:0];
    add_v    = ((a_q ^ add_r) & (add_m ^ add_r) & 8'h80) != 8'd0;
    cmp_diff = a_q - rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0;
      sp_q <= 8'hff; pc_q <= 16'd0; p_q <= 8'h20;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; x_q <= x_d; y_q <= y_d;
      sp_q <= sp_d; pc_q <= pc_d; p_q <= p_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    b1_q  <= b1_d;
    b2_q  <= b2_d;
    res_q <= res_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) begin
        case (req_i.cmd)
          CMD_READ: state_d = S_RD_WAIT;
          CMD_EXEC: state_d = S_OP;
          default:  state_d = S_IDLE;
        endcase
      end
      S_RD_WAIT: state_d = S_IDLE;
      S_OP:      state_d = S_B1;
      S_B1:      state_d = !need_b1 ? S_EXEC : (need_b2 ? S_B2 : (need_mem ? S_MEM_REQ : S_EXEC));
      S_B2:      state_d = need_mem ? S_MEM_REQ : S_EXEC;
      S_MEM_REQ: state_d = S_MEM_WAIT;
      S_MEM_WAIT: state_d = S_EXEC;
      S_EXEC:    state_d = (op_q == OP_JSR) ? S_PUSH_LO : S_IDLE;
      S_PUSH_LO: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; pc_d = pc_q; p_d = p_q;
    op_d = op_q; b1_d = b1_q; b2_d = b2_q;
    we = 1'b0; addr = pc_q; wdata = a_q;
    status_d = ST_OK; rbyte_d = 8'd0; rv_d = 1'b0;
    res_d = res_q;
    case (state_q)
      S_IDLE: begin
        // fetch the opcode while idle so it is ready in S_OP
        addr = (req_i.cmd == CMD_EXEC) ? pc_q : req_i.mem_address;
        wdata = req_i.mem_data;
        if (start) begin
          we = (req_i.cmd == CMD_WRITE);
          if (req_i.cmd == CMD_WRITE || req_i.cmd == CMD_NONE) rv_d = 1'b1;
        end
      end
      S_RD_WAIT: begin rbyte_d = rdata; rv_d = 1'b1; end
      S_OP: begin
        op_d = rdata;
        addr = pc_q + 16'd1;
      end
      S_B1: begin
        b1_d = rdata;
        addr = pc_q + 16'd2;
      end
      S_B2: b2_d = rdata;
      // hold the data address so the byte is still on rdata in S_EXEC
      S_MEM_REQ, S_MEM_WAIT: addr = mem_addr;
      S_EXEC: begin
        rv_d = 1'b1;
        case (op_q)
          OP_BRK: status_d = ST_BRK;
          OP_ASL: begin
            a_d = {a_q[6:0], 1'b0}; p_d[0] = a_q[7];
            p_d[1] = (a_d == 8'd0); p_d[7] = a_d[7]; pc_d = pc_q + 16'd1;
          end
          OP_JSR: begin
            we = 1'b1; addr = {8'h01, sp_q}; wdata = pc_q[15:8] + {7'd0, pc_q[7:0] > 8'hfd};
            sp_d = sp_q - 8'd1; rv_d = 1'b0;
          end
          OP_BMI: pc_d = pc_q + 16'd2 + (p_q[7] ? {{8{b1_q[7]}}, b1_q} : 16'd0);
          OP_ROLZX: begin
            we = 1'b1; addr = {8'd0, zpx}; wdata = {rdata[6:0], p_q[0]};
            p_d[0] = rdata[7]; p_d[1] = (wdata == 8'd0); p_d[7] = wdata[7];
            pc_d = pc_q + 16'd2;
          end
          OP_ADCZ, OP_ADCI, OP_SBC: begin
            a_d = add_r; p_d[0] = add_sum[8]; p_d[6] = add_v;
            p_d[1] = (add_r == 8'd0); p_d[7] = add_r[7]; pc_d = pc_q + 16'd2;
          end
          OP_STAZ: begin
            we = 1'b1; addr = {8'd0, b1_q}; wdata = a_q; pc_d = pc_q + 16'd2;
          end
          OP_TXA: begin
            a_d = x_q; p_d[1] = (x_q == 8'd0); p_d[7] = x_q[7]; pc_d = pc_q + 16'd1;
          end
          OP_LDY: begin
            y_d = b1_q; p_d[1] = (b1_q == 8'd0); p_d[7] = b1_q[7]; pc_d = pc_q + 16'd2;
          end
          OP_LDX: begin
            x_d = b1_q; p_d[1] = (b1_q == 8'd0); p_d[7] = b1_q[7]; pc_d = pc_q + 16'd2;
          end
          OP_LDA: begin
            a_d = b1_q; p_d[1] = (b1_q == 8'd0); p_d[7] = b1_q[7]; pc_d = pc_q + 16'd2;
          end
          OP_DEX: begin
            x_d = x_q - 8'd1; p_d[1] = (x_d == 8'd0); p_d[7] = x_d[7]; pc_d = pc_q + 16'd1;
          end
          OP_CMP: begin
            p_d[0] = (a_q >= rdata); p_d[1] = (a_q == rdata);
            p_d[7] = cmp_diff[7];
            pc_d = pc_q + 16'd3;
          end
          default: status_d = ST_UNKNOWN;
        endcase
      end
      S_PUSH_LO: begin
        we = 1'b1; addr = {8'h01, sp_q}; wdata = pc_q[7:0] + 8'd2;
        sp_d = sp_q - 8'd1; pc_d = {b2_q, b1_q}; rv_d = 1'b1;
      end
      default: ;
    endcase
    if (rv_d) begin
      res_d.status = status_d; res_d.read_byte = rbyte_d;
      res_d.acc_out = a_d; res_d.x_out = x_d; res_d.y_out = y_d;
      res_d.sp_out = sp_d; res_d.pc_out = pc_d; res_d.flags_out = p_d;
    end
  end

  assign busy = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign result_o = res_q;

endmodule
